>>> hdl/tc2p_pkg.sv
// Shared types, constants and helper functions of the true-color to palette index quantizer.
package tc2p_pkg;

    typedef enum logic [1:0] {
        DEPTH_8   = 2'd0,
        DEPTH_16  = 2'd1,
        DEPTH_256 = 2'd2
    } t_depth;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    localparam t_depth     DEPTH_RESET  = DEPTH_256;

    localparam logic [7:0] LO_THRESH    = 8'd85;
    localparam logic [7:0] HI_THRESH    = 8'd170;
    localparam logic [7:0] LO_ON_LEVEL  = 8'd170;
    localparam logic [7:0] LO_OFF_LEVEL = 8'd0;
    localparam logic [7:0] HI_ON_LEVEL  = 8'd255;
    localparam logic [7:0] HI_OFF_LEVEL = 8'd85;
    localparam logic [3:0] HI_BASE      = 4'd8;

    localparam logic [7:0]  GRAY_MUL    = 8'd205;
    localparam int          GRAY_SHIFT  = 11;
    localparam logic [4:0]  GRAY_STEPS  = 5'd25;
    localparam logic [7:0]  GRAY_BASE   = 8'd232;
    localparam logic [7:0]  GRAY_START  = 8'd15;
    localparam logic [7:0]  GRAY_STRIDE = 8'd10;

    localparam logic [7:0] CUBE_BASE    = 8'd16;
    localparam logic [7:0] CUBE_R_MUL   = 8'd36;
    localparam logic [7:0] CUBE_G_MUL   = 8'd6;

    // Six-level quantization used by the color cube.
    function automatic logic [2:0] f_level6(input logic [7:0] v);
        logic [2:0] lvl;
        begin
            if (v <= 8'd36) begin
                lvl = 3'd0;
            end else if (v <= 8'd99) begin
                lvl = 3'd1;
            end else if (v <= 8'd150) begin
                lvl = 3'd2;
            end else if (v <= 8'd195) begin
                lvl = 3'd3;
            end else if (v <= 8'd236) begin
                lvl = 3'd4;
            end else begin
                lvl = 3'd5;
            end
            return lvl;
        end
    endfunction

    // Channel value of one cube level.
    function automatic logic [7:0] f_cube_level(input logic [2:0] lvl);
        logic [7:0] v;
        begin
            unique case (lvl)
                3'd0:    v = 8'd0;
                3'd1:    v = 8'd73;
                3'd2:    v = 8'd126;
                3'd3:    v = 8'd174;
                3'd4:    v = 8'd217;
                default: v = 8'd255;
            endcase
            return v;
        end
    endfunction

    function automatic logic [7:0] f_absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Manhattan distance from a pixel to a palette color.
    function automatic logic [9:0] f_dist(input t_pixel p, input logic [7:0] cr,
                                          input logic [7:0] cg, input logic [7:0] cb);
        return {2'b00, f_absdiff(p.red, cr)} + {2'b00, f_absdiff(p.green, cg)}
             + {2'b00, f_absdiff(p.blue, cb)};
    endfunction

endpackage

>>> hdl/tc2p_if.sv
// Handshake channel interfaces for pixels, palette indexes and the depth register.
interface tc2p_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface tc2p_idx_if;
    logic       valid;
    logic       ready;
    logic [7:0] palette_index;

    modport source (output valid, output palette_index, input ready);
    modport sink   (input valid, input palette_index, output ready);
endinterface

interface tc2p_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] color_depth;

    modport source (output valid, output color_depth, input ready);
    modport sink   (input valid, input color_depth, output ready);
endinterface

>>> hdl/tc2p_quantize.sv
// Combinational candidate generation, distance calculation and nearest-color selection.
module tc2p_quantize (
    input  tc2p_pkg::t_pixel i_pixel,
    input  tc2p_pkg::t_depth i_depth,
    output logic [7:0]       o_palette_index
);

    logic [2:0]  lo_bits;
    logic [2:0]  hi_bits;
    logic [7:0]  lo_idx;
    logic [7:0]  hi_idx;
    logic [9:0]  d_lo;
    logic [9:0]  d_hi;

    logic [9:0]  gray_sum;
    logic [7:0]  gray_avg;
    logic [15:0] gray_prod;
    logic [4:0]  gray_k;
    logic [4:0]  gray_step;
    logic [7:0]  gray_idx;
    logic [7:0]  gray_lvl;
    logic [9:0]  d_gray;

    logic [2:0]  lvl_r;
    logic [2:0]  lvl_g;
    logic [2:0]  lvl_b;
    logic [7:0]  cube_idx;
    logic [9:0]  d_cube;

    assign lo_bits = {i_pixel.blue  >= tc2p_pkg::LO_THRESH,
                      i_pixel.green >= tc2p_pkg::LO_THRESH,
                      i_pixel.red   >= tc2p_pkg::LO_THRESH};
    assign hi_bits = {i_pixel.blue  >= tc2p_pkg::HI_THRESH,
                      i_pixel.green >= tc2p_pkg::HI_THRESH,
                      i_pixel.red   >= tc2p_pkg::HI_THRESH};

    assign lo_idx = {5'b00000, lo_bits};
    assign hi_idx = {4'b0000, tc2p_pkg::HI_BASE | {1'b0, hi_bits}};

    assign d_lo = tc2p_pkg::f_dist(i_pixel,
        lo_bits[0] ? tc2p_pkg::LO_ON_LEVEL : tc2p_pkg::LO_OFF_LEVEL,
        lo_bits[1] ? tc2p_pkg::LO_ON_LEVEL : tc2p_pkg::LO_OFF_LEVEL,
        lo_bits[2] ? tc2p_pkg::LO_ON_LEVEL : tc2p_pkg::LO_OFF_LEVEL);
    assign d_hi = tc2p_pkg::f_dist(i_pixel,
        hi_bits[0] ? tc2p_pkg::HI_ON_LEVEL : tc2p_pkg::HI_OFF_LEVEL,
        hi_bits[1] ? tc2p_pkg::HI_ON_LEVEL : tc2p_pkg::HI_OFF_LEVEL,
        hi_bits[2] ? tc2p_pkg::HI_ON_LEVEL : tc2p_pkg::HI_OFF_LEVEL);

    // Green counts twice in the gray average; the scale by 205/2048 maps it onto 26 steps.
    assign gray_sum  = {1'b0, i_pixel.green, 1'b0} + {2'b00, i_pixel.red}
                     + {2'b00, i_pixel.blue};
    assign gray_avg  = gray_sum[9:2];
    assign gray_prod = {8'h00, gray_avg} * {8'h00, tc2p_pkg::GRAY_MUL};
    assign gray_k    = gray_prod[15:tc2p_pkg::GRAY_SHIFT];

    always_comb begin
        if (gray_k == 5'd0) begin
            gray_step = 5'd0;
        end else if (gray_k >= tc2p_pkg::GRAY_STEPS) begin
            gray_step = tc2p_pkg::GRAY_STEPS - 5'd2;
        end else begin
            gray_step = gray_k - 5'd1;
        end
    end

    assign gray_idx = tc2p_pkg::GRAY_BASE + {3'b000, gray_step};
    assign gray_lvl = tc2p_pkg::GRAY_START + ({3'b000, gray_step} * tc2p_pkg::GRAY_STRIDE);
    assign d_gray   = tc2p_pkg::f_dist(i_pixel, gray_lvl, gray_lvl, gray_lvl);

    assign lvl_r    = tc2p_pkg::f_level6(i_pixel.red);
    assign lvl_g    = tc2p_pkg::f_level6(i_pixel.green);
    assign lvl_b    = tc2p_pkg::f_level6(i_pixel.blue);
    assign cube_idx = tc2p_pkg::CUBE_BASE + ({5'b00000, lvl_r} * tc2p_pkg::CUBE_R_MUL)
                    + ({5'b00000, lvl_g} * tc2p_pkg::CUBE_G_MUL) + {5'b00000, lvl_b};
    assign d_cube   = tc2p_pkg::f_dist(i_pixel, tc2p_pkg::f_cube_level(lvl_r),
                                       tc2p_pkg::f_cube_level(lvl_g),
                                       tc2p_pkg::f_cube_level(lvl_b));

    always_comb begin
        unique case (i_depth)
            tc2p_pkg::DEPTH_8: begin
                o_palette_index = lo_idx;
            end
            tc2p_pkg::DEPTH_16: begin
                // A tie goes to the bright half of the palette.
                o_palette_index = (d_lo < d_hi) ? lo_idx : hi_idx;
            end
            default: begin
                // The unused depth code behaves as the full palette.
                if (d_lo <= d_hi) begin
                    if (d_gray <= d_cube) begin
                        o_palette_index = (d_lo <= d_gray) ? lo_idx : gray_idx;
                    end else begin
                        o_palette_index = (d_lo <= d_cube) ? lo_idx : cube_idx;
                    end
                end else begin
                    if (d_gray <= d_cube) begin
                        o_palette_index = (d_hi <= d_gray) ? hi_idx : gray_idx;
                    end else begin
                        o_palette_index = (d_hi <= d_cube) ? hi_idx : cube_idx;
                    end
                end
            end
        endcase
    end

endmodule

>>> hdl/truecolor_to_palette_index_core.sv
// Top level of the true-color to palette index quantizer: input register, quantizer, result register.
// Path: an accepted pixel is held in the input register, and its palette index is loaded into
// the result register once that register is empty or being drained, and is shown on the output from there.
// Throughput: one pixel per clock; the input register keeps taking beats while a finished
// index waits in the result register, and stalls only when both registers are full.
// Reset (synchronous, active low) empties both registers and sets the depth to 256 colors.
module truecolor_to_palette_index_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tc2p_cfg_if.sink       i_cfg,
    tc2p_pix_if.sink       i_pix,
    tc2p_idx_if.source     o_idx
);

    tc2p_pkg::t_depth r_depth;
    tc2p_pkg::t_pixel r_pixel;
    logic             r_in_valid;
    logic [7:0]       r_index;
    logic             r_out_valid;

    tc2p_pkg::t_pixel n_pixel;
    logic [7:0]       n_index;
    logic             advance;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= tc2p_pkg::DEPTH_RESET;
        end else if (i_cfg.valid) begin
            r_depth <= tc2p_pkg::t_depth'(i_cfg.color_depth);
        end
    end

    // The input stage moves on whenever the result register is empty or being drained.
    assign advance     = !r_out_valid || o_idx.ready;
    assign i_pix.ready = !r_in_valid || advance;

    assign n_pixel = '{red: i_pix.red, green: i_pix.green, blue: i_pix.blue};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_pixel <= n_pixel;
        end
    end

    tc2p_quantize u_quantize (
        .i_pixel         (r_pixel),
        .i_depth         (r_depth),
        .o_palette_index (n_index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_index <= n_index;
        end
    end

    assign o_idx.valid         = r_out_valid;
    assign o_idx.palette_index = r_index;

endmodule
